[sv/wbs_pkg.sv]
// Shared constants, types and slot arithmetic for the windowed bucket statistics block.
package wbs_pkg;

   localparam int MAX_BUCKETS = 32;
   localparam int SAMPLE_BITS = 32;
   localparam int SLOT_W      = $clog2(MAX_BUCKETS);
   localparam int FILL_W      = $clog2(MAX_BUCKETS + 1);
   localparam int TIME_W      = 32;
   localparam int SUM_W       = 48;
   localparam int CNT_W       = 16;
   localparam int POS_W       = 5;
   localparam int RESULT_CAP  = 31;
   localparam int CFG_MS_W    = 22;
   localparam int STAT_W      = 3;
   localparam int CSR_IDX_W   = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BUCKET = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STAT   = 2'd2;

   localparam logic [STAT_W-1:0] STAT_MIN   = 3'd0;
   localparam logic [STAT_W-1:0] STAT_MAX   = 3'd1;
   localparam logic [STAT_W-1:0] STAT_SUM   = 3'd2;
   localparam logic [STAT_W-1:0] STAT_COUNT = 3'd3;
   localparam logic [STAT_W-1:0] STAT_AVG   = 3'd4;

   localparam logic ACT_ADD  = 1'b0;
   localparam logic ACT_READ = 1'b1;

   typedef struct packed {
      logic [TIME_W-1:0]             start_time;
      logic signed [SUM_W-1:0]       running_sum;
      logic [CNT_W-1:0]              sample_count;
      logic signed [SAMPLE_BITS-1:0] least_value;
      logic signed [SAMPLE_BITS-1:0] greatest_value;
   } bucket_type;

   localparam int BUCKET_W = $bits(bucket_type);

   // Ring slot that lies ofs places after base; ofs never exceeds the depth.
   function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] base,
                                                  input logic [FILL_W-1:0] ofs);
      logic [FILL_W:0] sum;
      sum = {{(FILL_W+1-SLOT_W){1'b0}}, base} + {1'b0, ofs};
      if (sum >= (FILL_W+1)'(MAX_BUCKETS))
         sum = sum - (FILL_W+1)'(MAX_BUCKETS);
      return sum[SLOT_W-1:0];
   endfunction

endpackage

[sv/wbs_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
module wbs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/windowed_bucket_statistics.sv]
// Top level of the windowed bucket statistics block: control sequencer around one bucket RAM.
//
//  Channel  Direction  Handshake                 Contents
//  req_     in         req_tvalid / req_tready   tdata: time_ms, sample_value; tuser: action
//  rsp_     out        rsp_tvalid / rsp_tready   tdata: stat_value, bucket_position;
//                                                tuser: none_ready; tlast: last
//  csr_     in         csr_valid / csr_ready     csr_index, csr_data
//
// One transaction at a time: after the accepting cycle, expiry inspects each bucket as its
// start is read from the RAM (registered read data) in S_EXP_RD, then compared in S_EXP_CHK.
// An add passes S_DISPAT, S_ADD_RD, S_ADD_CHK (S_DISPAT alone on an empty ring); a read
// passes S_DISPAT, then per result S_RD_RD, S_RD_CHK, S_DIV (averages, a bit a cycle), S_OUT.
// Reset is synchronous and active high and empties the ring; the RAM is not cleared.
// A result waits in its output register for as long as rsp_tready stays low.
module windowed_bucket_statistics (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] time_ms, [63:32] sample_value
   input  logic        req_tuser,   // [0] action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [47:0] stat_value, [52:48] bucket_position, rest zero
   output logic        rsp_tuser,   // [0] none_ready
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [21:0] csr_data
);

   localparam int SLOT_W = wbs_pkg::SLOT_W;
   localparam int FILL_W = wbs_pkg::FILL_W;
   localparam int SUM_W  = wbs_pkg::SUM_W;
   localparam int SB     = wbs_pkg::SAMPLE_BITS;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_EXP_RD  = 4'd1;
   localparam logic [3:0] S_EXP_CHK = 4'd2;
   localparam logic [3:0] S_DISPAT  = 4'd3;
   localparam logic [3:0] S_ADD_RD  = 4'd4;
   localparam logic [3:0] S_ADD_CHK = 4'd5;
   localparam logic [3:0] S_RD_RD   = 4'd6;
   localparam logic [3:0] S_RD_CHK  = 4'd7;
   localparam logic [3:0] S_DIV     = 4'd8;
   localparam logic [3:0] S_OUT     = 4'd9;

   logic [3:0]                          state_ff, state_in;
   logic [SLOT_W-1:0]                   oldest_ff, oldest_in;
   logic [FILL_W-1:0]                   fill_ff, fill_in;
   logic [wbs_pkg::CFG_MS_W-1:0]        window_ff, window_in, bucket_ff, bucket_in;
   logic [wbs_pkg::STAT_W-1:0]          stat_ff, stat_in;
   logic                                action_ff, action_in;
   logic [31:0]                         now_ff, now_in;
   logic signed [SB-1:0]                sample_ff, sample_in;
   logic [wbs_pkg::POS_W-1:0]           k_ff, k_in, n_ff, n_in;
   logic [SUM_W-1:0]                    quot_ff, quot_in;
   logic [wbs_pkg::CNT_W-1:0]           rem_ff, rem_in, den_ff, den_in;
   logic [5:0]                          dstep_ff, dstep_in;
   logic                                neg_ff, neg_in;
   logic [SUM_W-1:0]                    rsp_stat_ff, rsp_stat_in;
   logic [wbs_pkg::POS_W-1:0]           rsp_pos_ff, rsp_pos_in;
   logic                                rsp_last_ff, rsp_last_in, rsp_none_ff, rsp_none_in;

   logic                                ram_we;
   logic [SLOT_W-1:0]                   ram_wr_addr, ram_rd_addr;
   wbs_pkg::bucket_type                 ram_wr_data, rd_bkt;
   logic [wbs_pkg::BUCKET_W-1:0]        ram_rd_raw;

   logic [31:0]                         bkt_age;
   logic signed [SUM_W-1:0]             v48;
   logic signed [SUM_W:0]               sum_wide;
   logic [wbs_pkg::CNT_W:0]             trial;
   logic [SUM_W-1:0]                    sum_mag;
   logic [FILL_W-1:0]                   fill_m1;

   wbs_ram #(.WIDTH(wbs_pkg::BUCKET_W), .DEPTH(wbs_pkg::MAX_BUCKETS)) u_bucket_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_raw)
   );

   assign rd_bkt     = wbs_pkg::bucket_type'(ram_rd_raw);
   assign bkt_age    = now_ff - rd_bkt.start_time;
   assign v48        = SUM_W'(sample_ff);
   assign sum_wide   = {rd_bkt.running_sum[SUM_W-1], rd_bkt.running_sum} + {v48[SUM_W-1], v48};
   assign fill_m1    = fill_ff - FILL_W'(1);
   assign sum_mag    = rd_bkt.running_sum[SUM_W-1] ? (~rd_bkt.running_sum + SUM_W'(1))
                                                   : rd_bkt.running_sum;
   assign trial      = {rem_ff, quot_ff[SUM_W-1]};

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = {3'b000, rsp_pos_ff, rsp_stat_ff};
   assign rsp_tuser  = rsp_none_ff;
   assign rsp_tlast  = rsp_last_ff;

   // The read address follows the state that issues the read.
   always_comb begin
      case (state_ff)
         S_ADD_RD: ram_rd_addr = wbs_pkg::slot_add(oldest_ff, fill_m1);
         S_RD_RD:  ram_rd_addr = wbs_pkg::slot_add(oldest_ff, FILL_W'(k_ff));
         default:  ram_rd_addr = oldest_ff;
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      oldest_in   = oldest_ff;
      fill_in     = fill_ff;
      window_in   = window_ff;
      bucket_in   = bucket_ff;
      stat_in     = stat_ff;
      action_in   = action_ff;
      now_in      = now_ff;
      sample_in   = sample_ff;
      k_in        = k_ff;
      n_in        = n_ff;
      quot_in     = quot_ff;
      rem_in      = rem_ff;
      den_in      = den_ff;
      dstep_in    = dstep_ff;
      neg_in      = neg_ff;
      rsp_stat_in = rsp_stat_ff;
      rsp_pos_in  = rsp_pos_ff;
      rsp_last_in = rsp_last_ff;
      rsp_none_in = rsp_none_ff;
      ram_we      = 1'b0;
      ram_wr_addr = wbs_pkg::slot_add(oldest_ff, fill_ff);
      ram_wr_data.start_time     = now_ff;
      ram_wr_data.running_sum    = v48;
      ram_wr_data.sample_count   = wbs_pkg::CNT_W'(1);
      ram_wr_data.least_value    = sample_ff;
      ram_wr_data.greatest_value = sample_ff;

      if (csr_valid) begin
         case (csr_index)
            wbs_pkg::CSR_WINDOW: window_in = csr_data;
            wbs_pkg::CSR_BUCKET: bucket_in = csr_data;
            wbs_pkg::CSR_STAT:   stat_in   = csr_data[wbs_pkg::STAT_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               action_in = req_tuser;
               now_in    = req_tdata[31:0];
               sample_in = req_tdata[32 +: SB];
               state_in  = S_EXP_RD;
            end
         end
         S_EXP_RD: begin
            state_in = (fill_ff == '0) ? S_DISPAT : S_EXP_CHK;
         end
         S_EXP_CHK: begin
            // Drop the oldest bucket once its start lies beyond the window.
            if (bkt_age > {10'd0, window_ff}) begin
               oldest_in = wbs_pkg::slot_add(oldest_ff, FILL_W'(1));
               fill_in   = fill_m1;
               state_in  = S_EXP_RD;
            end else begin
               state_in  = S_DISPAT;
            end
         end
         S_DISPAT: begin
            if (action_ff == wbs_pkg::ACT_ADD) begin
               if (fill_ff == '0) begin
                  ram_we   = 1'b1;
                  fill_in  = FILL_W'(1);
                  state_in = S_IDLE;
               end else begin
                  state_in = S_ADD_RD;
               end
            end else if (fill_ff < FILL_W'(2)) begin
               rsp_stat_in = '0;
               rsp_pos_in  = '0;
               rsp_last_in = 1'b1;
               rsp_none_in = 1'b1;
               state_in    = S_OUT;
            end else begin
               k_in     = '0;
               n_in     = (fill_m1 > FILL_W'(wbs_pkg::RESULT_CAP))
                          ? wbs_pkg::POS_W'(wbs_pkg::RESULT_CAP)
                          : wbs_pkg::POS_W'(fill_m1);
               state_in = S_RD_RD;
            end
         end
         S_ADD_RD: begin
            state_in = S_ADD_CHK;
         end
         S_ADD_CHK: begin
            ram_we   = 1'b1;
            state_in = S_IDLE;
            if (bkt_age >= {10'd0, bucket_ff}) begin
               if (fill_ff == FILL_W'(wbs_pkg::MAX_BUCKETS)) begin
                  // A full ring reuses its oldest slot.
                  ram_wr_addr = oldest_ff;
                  oldest_in   = wbs_pkg::slot_add(oldest_ff, FILL_W'(1));
               end else begin
                  fill_in = fill_ff + FILL_W'(1);
               end
            end else begin
               ram_wr_addr = wbs_pkg::slot_add(oldest_ff, fill_m1);
               ram_wr_data = rd_bkt;
               if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
                  ram_wr_data.running_sum = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                                            : {1'b0, {(SUM_W-1){1'b1}}};
               else
                  ram_wr_data.running_sum = sum_wide[SUM_W-1:0];
               if (rd_bkt.sample_count != '1)
                  ram_wr_data.sample_count = rd_bkt.sample_count + wbs_pkg::CNT_W'(1);
               if (sample_ff < rd_bkt.least_value)
                  ram_wr_data.least_value = sample_ff;
               if (sample_ff > rd_bkt.greatest_value)
                  ram_wr_data.greatest_value = sample_ff;
            end
         end
         S_RD_RD: begin
            state_in = S_RD_CHK;
         end
         S_RD_CHK: begin
            rsp_pos_in  = k_ff;
            rsp_last_in = (k_ff + wbs_pkg::POS_W'(1) == n_ff);
            rsp_none_in = 1'b0;
            state_in    = S_OUT;
            case (stat_ff)
               wbs_pkg::STAT_MIN:   rsp_stat_in = SUM_W'(rd_bkt.least_value);
               wbs_pkg::STAT_MAX:   rsp_stat_in = SUM_W'(rd_bkt.greatest_value);
               wbs_pkg::STAT_SUM:   rsp_stat_in = rd_bkt.running_sum;
               wbs_pkg::STAT_COUNT: rsp_stat_in = SUM_W'(rd_bkt.sample_count);
               wbs_pkg::STAT_AVG: begin
                  rsp_stat_in = '0;
                  if (rd_bkt.sample_count != '0) begin
                     quot_in  = sum_mag;
                     rem_in   = '0;
                     den_in   = rd_bkt.sample_count;
                     neg_in   = rd_bkt.running_sum[SUM_W-1];
                     dstep_in = '0;
                     state_in = S_DIV;
                  end
               end
               default:             rsp_stat_in = '0;
            endcase
         end
         S_DIV: begin
            // Restoring division, one quotient bit per cycle.
            if (trial >= {1'b0, den_ff}) begin
               rem_in  = wbs_pkg::CNT_W'(trial - {1'b0, den_ff});
               quot_in = {quot_ff[SUM_W-2:0], 1'b1};
            end else begin
               rem_in  = trial[wbs_pkg::CNT_W-1:0];
               quot_in = {quot_ff[SUM_W-2:0], 1'b0};
            end
            dstep_in = dstep_ff + 6'd1;
            if (dstep_ff == 6'(SUM_W - 1)) begin
               rsp_stat_in = neg_ff ? (~quot_in + SUM_W'(1)) : quot_in;
               state_in    = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_tready) begin
               k_in     = k_ff + wbs_pkg::POS_W'(1);
               state_in = rsp_last_ff ? S_IDLE : S_RD_RD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         oldest_ff <= '0;
         fill_ff   <= '0;
         window_ff <= wbs_pkg::CFG_MS_W'(10000);
         bucket_ff <= wbs_pkg::CFG_MS_W'(1000);
         stat_ff   <= wbs_pkg::STAT_MIN;
      end else begin
         state_ff  <= state_in;
         oldest_ff <= oldest_in;
         fill_ff   <= fill_in;
         window_ff <= window_in;
         bucket_ff <= bucket_in;
         stat_ff   <= stat_in;
      end
      action_ff   <= action_in;
      now_ff      <= now_in;
      sample_ff   <= sample_in;
      k_ff        <= k_in;
      n_ff        <= n_in;
      quot_ff     <= quot_in;
      rem_ff      <= rem_in;
      den_ff      <= den_in;
      dstep_ff    <= dstep_in;
      neg_ff      <= neg_in;
      rsp_stat_ff <= rsp_stat_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_last_ff <= rsp_last_in;
      rsp_none_ff <= rsp_none_in;
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(wbs_pkg::MAX_BUCKETS))
      else $error("bucket fill exceeds ring depth");

   a_none_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("empty-ring result not marked last");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> den_ff != '0)
      else $error("divider running with zero count");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("transaction accepted while previous still in progress");

endmodule
